@@ src/hsv_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_pkg
// Shared widths, constants and types for the HSV to RGB PWM duty converter.
// ----------------------------------------------------------------------------
package hsv_pkg;

   // field widths
   localparam int LEVEL_BITS = 8;
   localparam int HUE_BITS   = 9;
   localparam int GAIN_W     = 8;
   localparam int DUTY_W     = 8;
   localparam int OFF_W      = 6;   // ramp offset, 0..60
   localparam int VS_W       = 2 * LEVEL_BITS;

   // csr port
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 2;

   localparam logic [CSR_IDX_W-1:0] REG_RED_GAIN   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_GREEN_GAIN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_BLUE_GAIN  = 2'd2;

   localparam logic [GAIN_W-1:0] RED_GAIN_RST   = 8'd255;
   localparam logic [GAIN_W-1:0] GREEN_GAIN_RST = 8'd185;
   localparam logic [GAIN_W-1:0] BLUE_GAIN_RST  = 8'd150;

   // fixed point: level numerators over DEN = 60 * FS * FS
   localparam int              HUE_SPAN = 60;
   localparam longint unsigned FS       = (64'd1 << LEVEL_BITS) - 64'd1;
   localparam longint unsigned DEN      = 64'd60 * FS * FS;
   localparam longint unsigned TOP_K    = 64'd60 * FS;
   localparam int              NUM_W    = $clog2(DEN + 64'd1);
   localparam int              PROD_W   = NUM_W + GAIN_W;

   // reciprocal of DEN, error below 2^-10 over the product range
   localparam int              SHIFT    = PROD_W + 10;
   localparam longint unsigned RECIP    = (64'd1 << SHIFT) / DEN;
   localparam int              RECIP_W  = SHIFT - $clog2(DEN) + 1;
   localparam int              MUL_W    = PROD_W + RECIP_W;

   localparam logic [NUM_W-1:0]  TOP_K_N  = NUM_W'(TOP_K);
   localparam logic [NUM_W-1:0]  SPAN_N   = NUM_W'(HUE_SPAN);
   localparam logic [PROD_W-1:0] DEN_P    = PROD_W'(DEN);
   localparam logic [MUL_W-1:0]  RECIP_M  = MUL_W'(RECIP);

   // sector bounds
   localparam logic [HUE_BITS-1:0] HUE_60  = HUE_BITS'(60);
   localparam logic [HUE_BITS-1:0] HUE_120 = HUE_BITS'(120);
   localparam logic [HUE_BITS-1:0] HUE_180 = HUE_BITS'(180);
   localparam logic [HUE_BITS-1:0] HUE_240 = HUE_BITS'(240);
   localparam logic [HUE_BITS-1:0] HUE_300 = HUE_BITS'(300);
   localparam logic [HUE_BITS-1:0] HUE_360 = HUE_BITS'(360);

   typedef enum logic [1:0] {
      SEL_MAX,
      SEL_MIN,
      SEL_RAMP,
      SEL_ZERO
   } chan_sel_type;

   typedef struct packed {
      chan_sel_type           red;
      chan_sel_type           green;
      chan_sel_type           blue;
      logic [OFF_W-1:0]       off;
   } sector_type;

endpackage

@@ src/hsv_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_if
// Request and response channels of the HSV to RGB PWM duty converter.
// ----------------------------------------------------------------------------
interface hsv_req_if;
   logic                             valid;
   logic                             ready;
   logic [hsv_pkg::HUE_BITS-1:0]     hue_deg;
   logic [hsv_pkg::LEVEL_BITS-1:0]   sat_level;
   logic [hsv_pkg::LEVEL_BITS-1:0]   bright_level;

   modport source (output valid, hue_deg, sat_level, bright_level, input ready);
   modport sink   (input valid, hue_deg, sat_level, bright_level, output ready);
endinterface

interface hsv_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [hsv_pkg::DUTY_W-1:0]   red_duty;
   logic [hsv_pkg::DUTY_W-1:0]   green_duty;
   logic [hsv_pkg::DUTY_W-1:0]   blue_duty;

   modport source (output valid, red_duty, green_duty, blue_duty, input ready);
   modport sink   (input valid, red_duty, green_duty, blue_duty, output ready);
endinterface

@@ src/hsv_to_rgb_pwm_duty.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsv_to_rgb_pwm_duty
// HSV color to per-channel LED PWM duty, five register stages.
// ----------------------------------------------------------------------------
// Path: an accepted request moves through register stages 1 to 5 in order.
// Throughput: one request per cycle unless stalled; each stage holds one
//   request and loads whenever it is empty or the one after it moves, so
//   bubbles close up and a stalled response holds only as far back as it must.
// Reset: clears all stage valid bits and loads the gain registers with
//   255 / 185 / 150. No clearing pass; requests are taken right after reset.
// ----------------------------------------------------------------------------
module hsv_to_rgb_pwm_duty (
   input  logic                              clock,
   input  logic                              reset,
   hsv_req_if.sink                           req_chan,
   hsv_rsp_if.source                         rsp_chan,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [hsv_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [hsv_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [hsv_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                              csr_pready
);

   // -------------------------------------------------------------------------
   // Gain registers. To be written only while idle (the block does not
   // enforce this), so the pipeline reads them directly in stage 3.
   // -------------------------------------------------------------------------
   logic [hsv_pkg::GAIN_W-1:0]    gain_ff [3];
   logic [hsv_pkg::GAIN_W-1:0]    gain_in [3];
   logic                          csr_wr;
   logic [hsv_pkg::CSR_IDX_W-1:0] csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel & csr_penable & csr_pwrite;
   assign csr_idx    = csr_paddr[hsv_pkg::CSR_ADDR_W-1:2];

   always_comb begin
      gain_in[0] = gain_ff[0];
      gain_in[1] = gain_ff[1];
      gain_in[2] = gain_ff[2];
      if (csr_wr) begin
         unique case (csr_idx)
            hsv_pkg::REG_RED_GAIN:   gain_in[0] = csr_pwdata[hsv_pkg::GAIN_W-1:0];
            hsv_pkg::REG_GREEN_GAIN: gain_in[1] = csr_pwdata[hsv_pkg::GAIN_W-1:0];
            hsv_pkg::REG_BLUE_GAIN:  gain_in[2] = csr_pwdata[hsv_pkg::GAIN_W-1:0];
            default: ;  // unmapped: write dropped
         endcase
      end
   end

   always_comb begin
      unique case (csr_idx)
         hsv_pkg::REG_RED_GAIN:   csr_prdata = hsv_pkg::CSR_DATA_W'(gain_ff[0]);
         hsv_pkg::REG_GREEN_GAIN: csr_prdata = hsv_pkg::CSR_DATA_W'(gain_ff[1]);
         hsv_pkg::REG_BLUE_GAIN:  csr_prdata = hsv_pkg::CSR_DATA_W'(gain_ff[2]);
         default:                 csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff[0] <= hsv_pkg::RED_GAIN_RST;
         gain_ff[1] <= hsv_pkg::GREEN_GAIN_RST;
         gain_ff[2] <= hsv_pkg::BLUE_GAIN_RST;
      end else begin
         gain_ff[0] <= gain_in[0];
         gain_ff[1] <= gain_in[1];
         gain_ff[2] <= gain_in[2];
      end
   end

   // -------------------------------------------------------------------------
   // Pipeline flow control. valid_ff[k] belongs to stage k+1; stage 5 is the
   // response register. A stage moves when empty or when the next one moves.
   // -------------------------------------------------------------------------
   logic [4:0] valid_ff;
   logic [4:0] valid_in;
   logic [4:0] adv;

   always_comb begin
      adv[4] = ~valid_ff[4] | rsp_chan.ready;
      for (int k = 3; k >= 0; k--) begin
         adv[k] = ~valid_ff[k] | adv[k+1];
      end
      valid_in[0] = adv[0] ? req_chan.valid : valid_ff[0];
      for (int k = 1; k < 5; k++) begin
         valid_in[k] = adv[k] ? valid_ff[k-1] : valid_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   assign req_chan.ready = adv[0];
   assign rsp_chan.valid = valid_ff[4];

   // -------------------------------------------------------------------------
   // Stage 1: sector decode, V*S and the max numerator 60*FS*V.
   // Zero saturation forces max on every channel (all levels equal V).
   // -------------------------------------------------------------------------
   hsv_pkg::sector_type              sec_in;
   logic [hsv_pkg::HUE_BITS-1:0]     off_full;
   logic [hsv_pkg::HUE_BITS-1:0]     hue;

   hsv_pkg::sector_type              sec1_ff;
   logic [hsv_pkg::VS_W-1:0]         vs1_ff;
   logic [hsv_pkg::NUM_W-1:0]        top1_ff;

   assign hue = req_chan.hue_deg;

   always_comb begin
      sec_in.red   = hsv_pkg::SEL_MAX;
      sec_in.green = hsv_pkg::SEL_MAX;
      sec_in.blue  = hsv_pkg::SEL_MAX;
      off_full     = '0;
      if (req_chan.sat_level == '0) begin
         // gray: keep the defaults
      end else if (hue < hsv_pkg::HUE_60) begin
         sec_in.green = hsv_pkg::SEL_RAMP;
         sec_in.blue  = hsv_pkg::SEL_MIN;
         off_full     = hue;
      end else if (hue < hsv_pkg::HUE_120) begin
         sec_in.red   = hsv_pkg::SEL_RAMP;
         sec_in.blue  = hsv_pkg::SEL_MIN;
         off_full     = hsv_pkg::HUE_120 - hue;
      end else if (hue < hsv_pkg::HUE_180) begin
         sec_in.red   = hsv_pkg::SEL_MIN;
         sec_in.blue  = hsv_pkg::SEL_RAMP;
         off_full     = hue - hsv_pkg::HUE_120;
      end else if (hue < hsv_pkg::HUE_240) begin
         sec_in.red   = hsv_pkg::SEL_MIN;
         sec_in.green = hsv_pkg::SEL_RAMP;
         off_full     = hsv_pkg::HUE_240 - hue;
      end else if (hue < hsv_pkg::HUE_300) begin
         sec_in.red   = hsv_pkg::SEL_RAMP;
         sec_in.green = hsv_pkg::SEL_MIN;
         off_full     = hue - hsv_pkg::HUE_240;
      end else if (hue <= hsv_pkg::HUE_360) begin
         // 360 lands here with a zero offset, i.e. blue at min
         sec_in.green = hsv_pkg::SEL_MIN;
         sec_in.blue  = hsv_pkg::SEL_RAMP;
         off_full     = hsv_pkg::HUE_360 - hue;
      end else begin
         // out-of-range hue: black
         sec_in.red   = hsv_pkg::SEL_ZERO;
         sec_in.green = hsv_pkg::SEL_ZERO;
         sec_in.blue  = hsv_pkg::SEL_ZERO;
      end
      sec_in.off = off_full[hsv_pkg::OFF_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv[0]) begin
         sec1_ff <= sec_in;
         vs1_ff  <= hsv_pkg::VS_W'(req_chan.sat_level) * hsv_pkg::VS_W'(req_chan.bright_level);
         top1_ff <= hsv_pkg::NUM_W'(req_chan.bright_level) * hsv_pkg::TOP_K_N;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 2: min = max - 60*VS, ramp = off*VS + min, per-channel select.
   // -------------------------------------------------------------------------
   logic [hsv_pkg::NUM_W-1:0] bot2;
   logic [hsv_pkg::NUM_W-1:0] ramp2;
   logic [hsv_pkg::NUM_W-1:0] num2_in [3];
   logic [hsv_pkg::NUM_W-1:0] num2_ff [3];
   hsv_pkg::chan_sel_type     sel2 [3];

   assign bot2  = top1_ff - hsv_pkg::NUM_W'(vs1_ff) * hsv_pkg::SPAN_N;
   assign ramp2 = hsv_pkg::NUM_W'(sec1_ff.off) * hsv_pkg::NUM_W'(vs1_ff) + bot2;
   assign sel2[0] = sec1_ff.red;
   assign sel2[1] = sec1_ff.green;
   assign sel2[2] = sec1_ff.blue;

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         unique case (sel2[c])
            hsv_pkg::SEL_MAX:  num2_in[c] = top1_ff;
            hsv_pkg::SEL_MIN:  num2_in[c] = bot2;
            hsv_pkg::SEL_RAMP: num2_in[c] = ramp2;
            default:           num2_in[c] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (adv[1]) begin
         num2_ff <= num2_in;
      end
   end

   // -------------------------------------------------------------------------
   // Stage 3: level numerator times channel gain.
   // -------------------------------------------------------------------------
   logic [hsv_pkg::PROD_W-1:0] prod3_ff [3];

   always_ff @(posedge clock) begin
      if (adv[2]) begin
         for (int c = 0; c < 3; c++) begin
            prod3_ff[c] <= hsv_pkg::PROD_W'(num2_ff[c]) * hsv_pkg::PROD_W'(gain_ff[c]);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage 4: quotient estimate by reciprocal; low by at most one.
   // -------------------------------------------------------------------------
   logic [hsv_pkg::MUL_W-1:0]  mul4 [3];
   logic [hsv_pkg::DUTY_W-1:0] q4_ff [3];
   logic [hsv_pkg::PROD_W-1:0] prod4_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         mul4[c] = hsv_pkg::MUL_W'(prod3_ff[c]) * hsv_pkg::RECIP_M;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[3]) begin
         for (int c = 0; c < 3; c++) begin
            q4_ff[c]    <= mul4[c][hsv_pkg::SHIFT +: hsv_pkg::DUTY_W];
            prod4_ff[c] <= prod3_ff[c];
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stage 5: remainder check, bump the estimate when it is one short.
   // -------------------------------------------------------------------------
   logic [hsv_pkg::PROD_W-1:0] rem5 [3];
   logic [hsv_pkg::DUTY_W-1:0] duty_ff [3];

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         rem5[c] = prod4_ff[c] - hsv_pkg::PROD_W'(q4_ff[c]) * hsv_pkg::DEN_P;
      end
   end

   always_ff @(posedge clock) begin
      if (adv[4]) begin
         for (int c = 0; c < 3; c++) begin
            duty_ff[c] <= q4_ff[c] + hsv_pkg::DUTY_W'(rem5[c] >= hsv_pkg::DEN_P);
         end
      end
   end

   assign rsp_chan.red_duty   = duty_ff[0];
   assign rsp_chan.green_duty = duty_ff[1];
   assign rsp_chan.blue_duty  = duty_ff[2];

   // -------------------------------------------------------------------------
   // Assertions
   // -------------------------------------------------------------------------
   a_accept_loads: assert property (@(posedge clock) disable iff (reset)
      req_chan.valid && req_chan.ready |=> valid_ff[0])
      else $error("accepted request not in stage 1");

   a_stall_only_full: assert property (@(posedge clock) disable iff (reset)
      !req_chan.ready |-> (valid_ff == 5'b11111))
      else $error("request stalled with a free stage");

   a_recip_bound: assert property (@(posedge clock) disable iff (reset)
      valid_ff[3] |-> (rem5[0] < hsv_pkg::DEN_P || rem5[0] - hsv_pkg::DEN_P < hsv_pkg::DEN_P)
                   && (rem5[1] < hsv_pkg::DEN_P || rem5[1] - hsv_pkg::DEN_P < hsv_pkg::DEN_P)
                   && (rem5[2] < hsv_pkg::DEN_P || rem5[2] - hsv_pkg::DEN_P < hsv_pkg::DEN_P))
      else $error("quotient estimate off by more than one");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("response valid after reset");

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the HSV to RGB PWM duty converter: a directed table
// of edge colors, then random colors under several gain settings, every
// response checked against a typed duty triple or an in-bench duty predictor.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int PIPE_LATENCY = 5;     // accept to response, no stall
   localparam int N_DIRECTED   = 23;

   // index past the last gain register, writes there must be dropped
   localparam logic [hsv_pkg::CSR_IDX_W-1:0] REG_UNUSED = 2'd3;

   // level numerators are kept exact over 60 * full_scale^2
   localparam longint unsigned LEVEL_MAX = (64'd1 << hsv_pkg::LEVEL_BITS) - 64'd1;
   localparam longint unsigned LEVEL_DEN = 64'd60 * LEVEL_MAX * LEVEL_MAX;

   typedef struct packed {
      logic [hsv_pkg::DUTY_W-1:0] red;
      logic [hsv_pkg::DUTY_W-1:0] green;
      logic [hsv_pkg::DUTY_W-1:0] blue;
   } duty_type;

   // one color request; typed rows carry a hand-written duty triple
   typedef struct packed {
      logic [hsv_pkg::HUE_BITS-1:0]   hue;
      logic [hsv_pkg::LEVEL_BITS-1:0] sat;
      logic [hsv_pkg::LEVEL_BITS-1:0] bright;
      logic                           typed;
      duty_type                       want;
   } color_row_type;

   logic clock;
   logic reset;

   logic                           csr_psel;
   logic                           csr_penable;
   logic                           csr_pwrite;
   logic [hsv_pkg::CSR_ADDR_W-1:0] csr_paddr;
   logic [hsv_pkg::CSR_DATA_W-1:0] csr_pwdata;
   logic [hsv_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   hsv_req_if req_bus ();
   hsv_rsp_if rsp_bus ();

   hsv_to_rgb_pwm_duty i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // bench copy of the gain registers
   logic [hsv_pkg::GAIN_W-1:0] gain_red   = hsv_pkg::RED_GAIN_RST;
   logic [hsv_pkg::GAIN_W-1:0] gain_green = hsv_pkg::GREEN_GAIN_RST;
   logic [hsv_pkg::GAIN_W-1:0] gain_blue  = hsv_pkg::BLUE_GAIN_RST;

   duty_type pending_duty[$];   // expected duties, oldest request first
   int    mismatches   = 0;
   int    colors_sent  = 0;
   int    duties_seen  = 0;
   int    gain_sets    = 1;
   int    cycles       = 0;
   bit    no_idle      = 0;  // shared by both sides: a stretch with no gaps
   int    stall_left   = 0;

   // edge colors; duties typed in only where they are obvious at reset gains
   color_row_type edge_rows [0:N_DIRECTED-1] = '{
      '{9'd0,   8'd0,   8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},    // black
      '{9'd0,   8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},    // pure red
      '{9'd120, 8'd255, 8'd255, 1'b1, {8'd0,   8'd185, 8'd0}},    // pure green
      '{9'd240, 8'd255, 8'd255, 1'b1, {8'd0,   8'd0,   8'd150}},  // pure blue
      '{9'd360, 8'd255, 8'd255, 1'b1, {8'd255, 8'd0,   8'd0}},    // 360 wraps to red
      '{9'd361, 8'd255, 8'd255, 1'b1, {8'd0,   8'd0,   8'd0}},    // out of range hue
      '{9'd511, 8'd255, 8'd255, 1'b1, {8'd0,   8'd0,   8'd0}},
      '{9'd511, 8'd0,   8'd255, 1'b1, {8'd255, 8'd185, 8'd150}},  // gray wins over hue
      '{9'd200, 8'd0,   8'd255, 1'b1, {8'd255, 8'd185, 8'd150}},  // white
      '{9'd0,   8'd255, 8'd0,   1'b1, {8'd0,   8'd0,   8'd0}},
      '{9'd361, 8'd1,   8'd1,   1'b1, {8'd0,   8'd0,   8'd0}},
      '{9'd60,  8'd255, 8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},    // sector borders
      '{9'd180, 8'd255, 8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd300, 8'd255, 8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd30,  8'd255, 8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},    // mid ramps
      '{9'd90,  8'd128, 8'd200, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd150, 8'd200, 8'd100, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd210, 8'd77,  8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd270, 8'd255, 8'd1,   1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd330, 8'd1,   8'd255, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd359, 8'd255, 8'd128, 1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd1,   8'd170, 8'd85,  1'b0, {8'd0,   8'd0,   8'd0}},
      '{9'd256, 8'd85,  8'd170, 1'b0, {8'd0,   8'd0,   8'd0}}     // hue bit 8 set
   };

   // 4 ns clock
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      mismatches++;
   endtask

   // Duty prediction: exact level numerators per sector, then one truncating
   // scale by the channel gain.
   function automatic duty_type predict_duty(logic [hsv_pkg::HUE_BITS-1:0] hue,
                                             logic [hsv_pkg::LEVEL_BITS-1:0] sat,
                                             logic [hsv_pkg::LEVEL_BITS-1:0] bright);
      longint unsigned h, s, v, vs, top, bot, lvl_r, lvl_g, lvl_b;
      duty_type d;
      h   = hue;
      s   = sat;
      v   = bright;
      vs  = v * s;
      top = 64'd60 * LEVEL_MAX * v;
      bot = top - 64'd60 * vs;
      if (s == 0) begin
         // no chroma: gray at the brightness level, hue ignored
         lvl_r = top;  lvl_g = top;  lvl_b = top;
      end else if (h < 60) begin
         lvl_r = top;  lvl_g = h * vs + bot;  lvl_b = bot;
      end else if (h < 120) begin
         lvl_r = (120 - h) * vs + bot;  lvl_g = top;  lvl_b = bot;
      end else if (h < 180) begin
         lvl_r = bot;  lvl_g = top;  lvl_b = (h - 120) * vs + bot;
      end else if (h < 240) begin
         lvl_r = bot;  lvl_g = (240 - h) * vs + bot;  lvl_b = top;
      end else if (h < 300) begin
         lvl_r = (h - 240) * vs + bot;  lvl_g = bot;  lvl_b = top;
      end else if (h <= 360) begin
         lvl_r = top;  lvl_g = bot;  lvl_b = (360 - h) * vs + bot;
      end else begin
         lvl_r = 0;  lvl_g = 0;  lvl_b = 0;
      end
      d.red   = hsv_pkg::DUTY_W'((lvl_r * gain_red) / LEVEL_DEN);
      d.green = hsv_pkg::DUTY_W'((lvl_g * gain_green) / LEVEL_DEN);
      d.blue  = hsv_pkg::DUTY_W'((lvl_b * gain_blue) / LEVEL_DEN);
      return d;
   endfunction

   // APB write: setup, access, register loads on the access edge.
   // Leading edge wait keeps psel from being dropped and raised in one step.
   task automatic csr_write(logic [hsv_pkg::CSR_IDX_W-1:0] idx,
                            logic [hsv_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= hsv_pkg::CSR_ADDR_W'({idx, 2'b00});
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         hsv_pkg::REG_RED_GAIN:   gain_red   = data[hsv_pkg::GAIN_W-1:0];
         hsv_pkg::REG_GREEN_GAIN: gain_green = data[hsv_pkg::GAIN_W-1:0];
         hsv_pkg::REG_BLUE_GAIN:  gain_blue  = data[hsv_pkg::GAIN_W-1:0];
         default: ;      // unmapped, dropped
      endcase
   endtask

   // APB read, prdata sampled on the access edge
   task automatic csr_read_check(logic [hsv_pkg::CSR_IDX_W-1:0] idx,
                                 logic [hsv_pkg::GAIN_W-1:0] want);
      logic [hsv_pkg::CSR_DATA_W-1:0] got;
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= hsv_pkg::CSR_ADDR_W'({idx, 2'b00});
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      got = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== hsv_pkg::CSR_DATA_W'(want))
         report_mismatch($sformatf("gain reg %0d read %0h expected %0h", idx, got, want));
   endtask

   // new gain set; junk in the upper data bits must be masked off
   task automatic program_gains(logic [hsv_pkg::GAIN_W-1:0] r,
                                logic [hsv_pkg::GAIN_W-1:0] g,
                                logic [hsv_pkg::GAIN_W-1:0] b);
      csr_write(hsv_pkg::REG_RED_GAIN,   {24'($urandom), r});
      csr_write(hsv_pkg::REG_GREEN_GAIN, {24'($urandom), g});
      csr_write(hsv_pkg::REG_BLUE_GAIN,  {24'($urandom), b});
      csr_write(REG_UNUSED,              32'($urandom));
      csr_read_check(hsv_pkg::REG_RED_GAIN,   gain_red);
      csr_read_check(hsv_pkg::REG_GREEN_GAIN, gain_green);
      csr_read_check(hsv_pkg::REG_BLUE_GAIN,  gain_blue);
      gain_sets++;
   endtask

   // One request. valid stays high across back-to-back requests and this task
   // drops it only when a gap is drawn, so it never sees two assignments per step.
   task automatic send_color(color_row_type row);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 7);
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid        <= 1'b1;
      req_bus.hue_deg      <= row.hue;
      req_bus.sat_level    <= row.sat;
      req_bus.bright_level <= row.bright;
      do @(posedge clock); while (!req_bus.ready);
      pending_duty.push_back(row.typed ? row.want
                                       : predict_duty(row.hue, row.sat, row.bright));
      colors_sent++;
   endtask

   // wait for every outstanding request to come back, then let the pipe settle
   task automatic drain_pipeline();
      while (pending_duty.size() != 0) @(posedge clock);
      repeat (PIPE_LATENCY + 3) @(posedge clock);
   endtask

   // Response side: check each accepted response against the oldest
   // expectation, then draw the stall before the next one.
   always @(posedge clock) begin
      duty_type want;
      logic     ready_next;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         duties_seen++;
         if (pending_duty.size() == 0) begin
            report_mismatch($sformatf("response %0h/%0h/%0h with no request outstanding",
                                      rsp_bus.red_duty, rsp_bus.green_duty,
                                      rsp_bus.blue_duty));
         end else begin
            want = pending_duty.pop_front();
            if (rsp_bus.red_duty !== want.red)
               report_mismatch($sformatf("red_duty %0d expected %0d",
                                         rsp_bus.red_duty, want.red));
            if (rsp_bus.green_duty !== want.green)
               report_mismatch($sformatf("green_duty %0d expected %0d",
                                         rsp_bus.green_duty, want.green));
            if (rsp_bus.blue_duty !== want.blue)
               report_mismatch($sformatf("blue_duty %0d expected %0d",
                                         rsp_bus.blue_duty, want.blue));
         end
         stall_left = no_idle ? 0 : $urandom_range(0, 7);
      end
      if (stall_left > 0) begin
         stall_left--;
         ready_next = 1'b0;
      end else begin
         ready_next = 1'b1;
      end
      rsp_bus.ready <= ready_next;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d requests outstanding",
                  cycles, pending_duty.size());
         $display("Regression FAIL");
         $finish;
      end
   end

   initial begin
      color_row_type row;
      int            pick;
      int            n_random;

      // every input known from time zero
      reset                = 1'b1;
      req_bus.valid        = 1'b0;
      req_bus.hue_deg      = '0;
      req_bus.sat_level    = '0;
      req_bus.bright_level = '0;
      rsp_bus.ready        = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // phase 0 runs at the reset gains; later phases reprogram them,
      // with both extremes (all zero, all full) among the settings
      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 0) begin
            csr_read_check(hsv_pkg::REG_RED_GAIN,   hsv_pkg::RED_GAIN_RST);
            csr_read_check(hsv_pkg::REG_GREEN_GAIN, hsv_pkg::GREEN_GAIN_RST);
            csr_read_check(hsv_pkg::REG_BLUE_GAIN,  hsv_pkg::BLUE_GAIN_RST);
            for (int i = 0; i < N_DIRECTED; i++)
               send_color(edge_rows[i]);
         end else begin
            req_bus.valid <= 1'b0;
            drain_pipeline();
            case (phase)
               1: program_gains(8'd0, 8'd0, 8'd0);
               2: program_gains(8'd255, 8'd255, 8'd255);
               3: program_gains(8'($urandom), 8'($urandom), 8'($urandom));
               default: program_gains(8'd1, 8'($urandom), 8'd254);
            endcase
         end

         n_random = (phase == 0) ? 80 : 105;
         for (int n = 0; n < n_random; n++) begin
            // every 40 requests, maybe a stretch where neither side idles
            if (n % 40 == 0)
               no_idle = ($urandom_range(0, 3) == 0);
            row.hue    = hsv_pkg::HUE_BITS'($urandom_range(0, 360));
            row.sat    = hsv_pkg::LEVEL_BITS'($urandom_range(0, 255));
            row.bright = hsv_pkg::LEVEL_BITS'($urandom_range(0, 255));
            row.typed  = 1'b0;
            row.want   = '0;
            pick = $urandom_range(0, 9);
            case (pick)
               0: row.hue = hsv_pkg::HUE_BITS'($urandom_range(361, 511));   // past 360
               1: row.sat = '0;                                              // gray
               2: begin                                                      // full color
                  row.sat    = '1;
                  row.bright = '1;
               end
               3: row.hue = hsv_pkg::HUE_BITS'(60 * $urandom_range(0, 6));  // border
               default: ;
            endcase
            send_color(row);
         end
         no_idle = 1'b0;
      end

      req_bus.valid <= 1'b0;
      drain_pipeline();
      repeat (20) @(posedge clock);

      $display("Sent %0d colors over %0d gain settings, %0d duty triples checked,",
               colors_sent, gain_sets, duties_seen);
      $display("  %0d mismatches, %0d still outstanding",
               mismatches, pending_duty.size());
      if (mismatches == 0 && pending_duty.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
